// ----- src/gtiw_pkg.sv -----
// ----------------------------------------------------------------------------
// gtiw_pkg
// shared widths, calendar constants, stage types and arithmetic helpers for
// the gregorian to iso week date converter
// ----------------------------------------------------------------------------
package gtiw_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ORD_W   = 9;
  localparam int WEEK_W  = 6;
  localparam int WD_W    = 3;
  localparam int Q100_W  = 8;
  localparam int MOD_W   = 3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [WEEK_W-1:0] LONG_WEEKS  = 6'd53;
  localparam logic [WEEK_W-1:0] SHORT_WEEKS = 6'd52;
  localparam logic [WEEK_W-1:0] FIRST_WEEK  = 6'd1;

  // year_mod codes that mark a 53 week year
  localparam logic [MOD_W-1:0] YM_THU = 3'd4;
  localparam logic [MOD_W-1:0] YM_WED = 3'd3;

  localparam logic [WD_W-1:0] WD_SUNDAY = 3'd7;
  localparam logic [ORD_W-1:0] ISO_WEEK_BIAS = 9'd10;

  // floor(x / 100) for 14 bit x: x * 5243 >> 19
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP100_SH = 19;
  // floor(v / 7) for v below 512: v * 293 >> 11
  localparam logic [8:0]  RECIP7      = 9'd293;
  localparam int          RECIP7_SH   = 11;

  typedef struct packed {
    logic                  ok;
    logic [DAY_W-1:0]      day;
    logic [MONTH_W-1:0]    month;
    logic [YEAR_W-1:0]     year;
    logic [Q100_W-1:0]     q_cur;
    logic [Q100_W-1:0]     q_p1;
    logic [Q100_W-1:0]     q_p2;
  } front_t;

  typedef struct packed {
    logic                  ok;
    logic [ORD_W-1:0]      ord;
    logic [YEAR_W-1:0]     year;
    logic [MOD_W-1:0]      ym_cur;
    logic [MOD_W-1:0]      ym_p1;
    logic [MOD_W-1:0]      ym_p2;
    logic                  y_ge2;
  } yinfo_t;

  typedef struct packed {
    logic                  ok;
    logic [ORD_W-1:0]      ord;
    logic [YEAR_W-1:0]     year;
    logic [WD_W-1:0]       wd;
    logic [WEEK_W-1:0]     wk;
    logic                  long_cur;
    logic                  long_prev;
  } wraw_t;

  typedef struct packed {
    logic                  valid_res;
    logic [ORD_W-1:0]      ordinal_day;
    logic [YEAR_W-1:0]     iso_year;
    logic [WEEK_W-1:0]     iso_week;
    logic [WD_W-1:0]       weekday;
  } res_t;

  // days before the first of the month in a common year
  function automatic logic [ORD_W-1:0] month_base(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] b;
    unique case (m)
      4'd1:    b = 9'd0;
      4'd2:    b = 9'd31;
      4'd3:    b = 9'd59;
      4'd4:    b = 9'd90;
      4'd5:    b = 9'd120;
      4'd6:    b = 9'd151;
      4'd7:    b = 9'd181;
      4'd8:    b = 9'd212;
      4'd9:    b = 9'd243;
      4'd10:   b = 9'd273;
      4'd11:   b = 9'd304;
      4'd12:   b = 9'd334;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'(RECIP100);
    return prod[RECIP100_SH+Q100_W-1:RECIP100_SH];
  endfunction

  // 8 = 1 mod 7: fold octal digits
  function automatic logic [MOD_W-1:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
       + 6'(x[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // (x + x/4 - x/100 + x/400) mod 7, q = x/100
  function automatic logic [MOD_W-1:0] year_mod(input logic [YEAR_W-1:0] x,
                                                input logic [Q100_W-1:0] q);
    logic [15:0] s;
    s = 16'(x) + 16'(x[YEAR_W-1:2]) - 16'(q) + 16'(q[Q100_W-1:2]);
    return mod7(s);
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] x,
                                   input logic [Q100_W-1:0] q);
    logic [15:0] hund;
    hund = 16'(q) * 16'd100;
    return (x[1:0] == 2'd0) && ((16'(x) != hund) || (q[1:0] == 2'd0));
  endfunction

endpackage

// ----- src/gtiw_front.sv -----
// ----------------------------------------------------------------------------
// gtiw_front
// first stage: range check and century quotients of year, year-1, year-2
// ----------------------------------------------------------------------------
module gtiw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [gtiw_pkg::DAY_W-1:0]   day_i,
  input  logic [gtiw_pkg::MONTH_W-1:0] month_i,
  input  logic [gtiw_pkg::YEAR_W-1:0]  year_i,
  output logic                        vld_o,
  output gtiw_pkg::front_t            data_o
);
  import gtiw_pkg::*;

  logic   vld_r;
  front_t data_r;
  front_t data_nxt;

  always_comb begin
    data_nxt.ok    = (day_i != '0) && (month_i != '0) && (month_i <= MONTH_DEC) &&
                     (year_i != '0);
    data_nxt.day   = day_i;
    data_nxt.month = month_i;
    data_nxt.year  = year_i;
    data_nxt.q_cur = div100(year_i);
    data_nxt.q_p1  = div100(year_i - YEAR_W'(1));
    data_nxt.q_p2  = div100(year_i - YEAR_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

// ----- src/gtiw_year.sv -----
// ----------------------------------------------------------------------------
// gtiw_year
// second stage: leap flag, ordinal day and year weekday codes
// ----------------------------------------------------------------------------
module gtiw_year (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  gtiw_pkg::front_t data_i,
  output logic             vld_o,
  output gtiw_pkg::yinfo_t data_o
);
  import gtiw_pkg::*;

  logic              vld_r;
  yinfo_t            data_r;
  yinfo_t            data_nxt;
  logic              leap;
  logic [YEAR_W-1:0] y_p1;
  logic [YEAR_W-1:0] y_p2;

  always_comb begin
    y_p1 = data_i.year - YEAR_W'(1);
    y_p2 = data_i.year - YEAR_W'(2);
    leap = is_leap(data_i.year, data_i.q_cur);
    data_nxt.ok     = data_i.ok;
    data_nxt.year   = data_i.year;
    data_nxt.ord    = month_base(data_i.month)
                    + ORD_W'(leap && (data_i.month > MONTH_FEB))
                    + ORD_W'(data_i.day);
    data_nxt.ym_cur = year_mod(data_i.year, data_i.q_cur);
    data_nxt.ym_p1  = year_mod(y_p1, data_i.q_p1);
    data_nxt.ym_p2  = year_mod(y_p2, data_i.q_p2);
    data_nxt.y_ge2  = (data_i.year >= YEAR_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

// ----- src/gtiw_week.sv -----
// ----------------------------------------------------------------------------
// gtiw_week
// third and fourth stages: weekday and raw week number, then year rollover
// ----------------------------------------------------------------------------
module gtiw_week (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  gtiw_pkg::yinfo_t data_i,
  output logic             vld_o,
  output gtiw_pkg::res_t   data_o
);
  import gtiw_pkg::*;

  logic              raw_vld_r;
  wraw_t             raw_r;
  wraw_t             raw_nxt;
  logic              res_vld_r;
  res_t              res_r;
  res_t              res_nxt;
  logic [MOD_W-1:0]  wd0;
  logic [ORD_W-1:0]  wk_num;
  logic [17:0]       wk_prod;
  logic [WEEK_W-1:0] wk_max;

  // weekday = (jan 1 weekday + ord - 1) mod 7, jan 1 weekday = ym(y-1) + 1
  always_comb begin
    wd0     = mod7(16'(data_i.ord) + 16'(data_i.ym_p1));
    raw_nxt.wd = (wd0 == '0) ? WD_SUNDAY : wd0;
    wk_num  = data_i.ord + ISO_WEEK_BIAS - ORD_W'(raw_nxt.wd);
    wk_prod = 18'(wk_num) * 18'(RECIP7);
    raw_nxt.wk        = wk_prod[RECIP7_SH+WEEK_W-1:RECIP7_SH];
    raw_nxt.ok        = data_i.ok;
    raw_nxt.ord       = data_i.ord;
    raw_nxt.year      = data_i.year;
    raw_nxt.long_cur  = (data_i.ym_cur == YM_THU) || (data_i.ym_p1 == YM_WED);
    raw_nxt.long_prev = (data_i.ym_p1 == YM_THU) ||
                        (data_i.y_ge2 && (data_i.ym_p2 == YM_WED));
  end

  always_comb begin
    wk_max = raw_r.long_cur ? LONG_WEEKS : SHORT_WEEKS;
    res_nxt.valid_res   = raw_r.ok;
    res_nxt.ordinal_day = raw_r.ord;
    res_nxt.weekday     = raw_r.wd;
    res_nxt.iso_year    = raw_r.year;
    res_nxt.iso_week    = raw_r.wk;
    priority if (raw_r.wk == '0) begin
      // belongs to the last week of the previous year
      res_nxt.iso_year = raw_r.year - YEAR_W'(1);
      res_nxt.iso_week = raw_r.long_prev ? LONG_WEEKS : SHORT_WEEKS;
    end else if (raw_r.wk > wk_max) begin
      res_nxt.iso_year = raw_r.year + YEAR_W'(1);
      res_nxt.iso_week = FIRST_WEEK;
    end else begin
      res_nxt.iso_week = raw_r.wk;
    end
    if (!raw_r.ok) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else if (en) begin
      raw_vld_r <= vld_i;
      res_vld_r <= raw_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r <= raw_nxt;
      res_r <= res_nxt;
    end
  end

  assign vld_o  = res_vld_r;
  assign data_o = res_r;

endmodule

// ----- src/gtiw_skid.sv -----
// ----------------------------------------------------------------------------
// gtiw_skid
// two entry output buffer, ready toward the pipeline comes from a register
// ----------------------------------------------------------------------------
module gtiw_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_vld,
  input  gtiw_pkg::res_t push_data,
  output logic           push_rdy,
  output logic           out_vld,
  output gtiw_pkg::res_t out_data,
  input  logic           out_rdy
);
  import gtiw_pkg::*;

  logic out_vld_r;
  logic spare_vld_r;
  res_t out_data_r;
  res_t spare_data_r;
  logic out_free;

  assign out_free = !out_vld_r || out_rdy;
  assign push_rdy = !spare_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_r   <= spare_vld_r || push_vld;
        spare_vld_r <= 1'b0;
      end else if (push_vld && !spare_vld_r) begin
        spare_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= spare_vld_r ? spare_data_r : push_data;
    end
    if (!out_free && !spare_vld_r) begin
      spare_data_r <= push_data;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

// ----- src/gregorian_to_iso_week_date_core.sv -----
// ----------------------------------------------------------------------------
// gregorian_to_iso_week_date_core
// converts a gregorian day, month and year into ordinal day and iso 8601
// week date (week-based year, week, weekday monday 1 .. sunday 7)
// ----------------------------------------------------------------------------
// path: an accepted transaction passes four pipeline registers, then the
//   output buffer register, before it shows on out_tvalid
// throughput: one transaction per cycle while in_tready is high
// reset: rst_n low at a clock edge empties the pipeline and the output buffer
// ----------------------------------------------------------------------------
module gregorian_to_iso_week_date_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // day[4:0], month[8:5], year[22:9], zero fill [23]
  input  logic [gtiw_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // ordinal_day[8:0], iso_year[22:9], iso_week[28:23], weekday[31:29]
  output logic [gtiw_pkg::OUT_DATA_W-1:0]    out_tdata,
  // valid_res[0]
  output logic                               out_tuser
);
  import gtiw_pkg::*;

  // the whole pipeline moves together while the output buffer has room;
  // valid bits travel with the data so bubbles pass through harmlessly
  logic   pipe_rdy;
  logic   in_acc;

  logic   s1_vld;
  front_t s1_data;
  logic   s2_vld;
  yinfo_t s2_data;
  logic   s4_vld;
  res_t   s4_data;
  res_t   out_res;

  assign in_tready = pipe_rdy;
  assign in_acc    = in_tvalid && pipe_rdy;

  // stage 1: range check and century quotients
  gtiw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_rdy),
    .vld_i   (in_acc),
    .day_i   (in_tdata[DAY_W-1:0]),
    .month_i (in_tdata[DAY_W+MONTH_W-1:DAY_W]),
    .year_i  (in_tdata[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W]),
    .vld_o   (s1_vld),
    .data_o  (s1_data)
  );

  // stage 2: leap year, ordinal day, weekday codes of year-end
  gtiw_year u_year (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_rdy),
    .vld_i  (s1_vld),
    .data_i (s1_data),
    .vld_o  (s2_vld),
    .data_o (s2_data)
  );

  // stages 3 and 4: weekday, week number, rollover into the adjacent year
  gtiw_week u_week (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_rdy),
    .vld_i  (s2_vld),
    .data_i (s2_data),
    .vld_o  (s4_vld),
    .data_o (s4_data)
  );

  // output register plus spare entry, so a stalled sink never drops a result
  gtiw_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (s4_vld && pipe_rdy),
    .push_data (s4_data),
    .push_rdy  (pipe_rdy),
    .out_vld   (out_tvalid),
    .out_data  (out_res),
    .out_rdy   (out_tready)
  );

  assign out_tuser = out_res.valid_res;
  assign out_tdata = {out_res.weekday, out_res.iso_week, out_res.iso_year,
                      out_res.ordinal_day};

  // a full spare entry always sits behind a held output
  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_rdy |-> out_tvalid)
    else $error("output buffer spare full with no result on the port");

  // a rejected date carries all zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("invalid date result carries nonzero fields");

  // a good date always yields a legal week and weekday
  a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ((out_res.weekday != '0) && (out_res.iso_week != '0) &&
       (out_res.iso_week <= LONG_WEEKS) && (out_res.ordinal_day != '0)))
    else $error("week date fields out of range");

endmodule
